[rtl/mef_pkg.sv]
// Shared constants, codes and control types for the moisture filter.
package mef_pkg;

  // Smoothing weight format: unsigned Q0.16 held in 17 bits so that 1.0 fits.
  localparam int ALPHA_BITS  = 16;
  localparam int WEIGHT_BITS = ALPHA_BITS + 1;
  localparam logic [WEIGHT_BITS-1:0] ALPHA_ONE = WEIGHT_BITS'(1) << ALPHA_BITS;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = WEIGHT_BITS'(13107);

  // Percent output.
  localparam int PCT_BITS = 7;
  localparam logic [PCT_BITS-1:0] PCT_MAX = PCT_BITS'(100);
  // Scale factor 100 left-aligned in the multiplier operand, walked MSB first.
  localparam int PCT_MUL_STEPS = 7;
  localparam logic [WEIGHT_BITS-1:0] PCT_SCALE_ALIGNED =
    WEIGHT_BITS'(100) << (WEIGHT_BITS - PCT_MUL_STEPS);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DRY_POINT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WET_POINT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = CFG_IDX_W'(2);

  // Calibration reset points.
  localparam int DRY_RESET = 505;
  localparam int WET_RESET = 205;

  // Shared unit operations.
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  localparam int STEP_W = 5;

  typedef struct packed {
    logic              start;
    logic              op;
    logic [STEP_W-1:0] steps;
  } mef_ctl_t;

endpackage

[rtl/mef_median.sv]
// Sample window storage and rank-based median search, one candidate per cycle.
module mef_median import mef_pkg::*; #(
  parameter int WINDOW      = 5,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [$clog2(WINDOW)-1:0]  wr_slot,
  input  logic [SAMPLE_BITS-1:0]     wr_data,
  input  logic                       start,
  output logic                       done,
  output logic [SAMPLE_BITS-1:0]     median
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int RANK_W = $clog2(WINDOW + 1);
  localparam int HALF   = WINDOW / 2;

  logic [SAMPLE_BITS-1:0] win_r [WINDOW];
  logic [SLOT_W-1:0]      idx_r;
  logic                   busy_r;
  logic                   done_r;
  logic [SAMPLE_BITS-1:0] med_r;

  logic [SAMPLE_BITS-1:0] cand;
  logic [RANK_W-1:0]      n_less;
  logic [RANK_W-1:0]      n_leq;
  logic                   hit;

  // Candidate is the median when at most HALF entries are below it and more
  // than HALF are at or below it.
  always_comb begin
    cand   = win_r[idx_r];
    n_less = '0;
    n_leq  = '0;
    for (int j = 0; j < WINDOW; j++) begin
      n_less = n_less + RANK_W'(win_r[j] < cand);
      n_leq  = n_leq + RANK_W'(win_r[j] <= cand);
    end
    hit = (n_less <= RANK_W'(HALF)) && (n_leq > RANK_W'(HALF));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_r[wr_slot] <= wr_data;
    end
    if (busy_r && hit) begin
      med_r <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r) begin
        if (hit) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          idx_r <= idx_r + SLOT_W'(1);
        end
      end
    end
  end

  assign done   = done_r;
  assign median = med_r;

endmodule

[rtl/mef_unit.sv]
// Shared bit-serial unit: shift-add multiply and restoring divide.
module mef_unit import mef_pkg::*; #(
  parameter int OPND_W      = 29,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mef_ctl_t                      ctl,
  input  logic [OPND_W-1:0]             opnd_a,
  input  logic [WEIGHT_BITS-1:0]        opnd_b,
  input  logic [SAMPLE_BITS-1:0]        divisor,
  output logic                          done,
  output logic [OPND_W+WEIGHT_BITS-1:0] result
);

  localparam int PW = OPND_W + WEIGHT_BITS;
  localparam int NW = SAMPLE_BITS + PCT_MUL_STEPS;

  logic              busy_r;
  logic              done_r;
  logic              op_r;
  logic [STEP_W-1:0] cnt_r;
  logic [OPND_W-1:0] a_r;
  logic [WEIGHT_BITS-1:0] b_r;
  logic [PW-1:0]     acc_r;
  logic [SAMPLE_BITS-1:0] rem_r;

  logic [PW-1:0]          a_ext;
  logic [SAMPLE_BITS:0]   shifted;
  logic [SAMPLE_BITS+1:0] trial;
  logic                   qbit;

  always_comb begin
    a_ext   = {{(PW - OPND_W){a_r[OPND_W-1]}}, a_r};
    shifted = {rem_r, acc_r[NW-1]};
    trial   = {1'b0, shifted} - {2'b00, divisor};
    qbit    = ~trial[SAMPLE_BITS+1];
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r   <= opnd_a;
      b_r   <= opnd_b;
      acc_r <= (ctl.op == OP_DIV) ? PW'(opnd_a) : '0;
      rem_r <= '0;
    end else if (busy_r) begin
      case (op_r)
        OP_MUL: begin
          acc_r <= {acc_r[PW-2:0], 1'b0} + (b_r[WEIGHT_BITS-1] ? a_ext : '0);
          b_r   <= {b_r[WEIGHT_BITS-2:0], 1'b0};
        end
        OP_DIV: begin
          acc_r <= {acc_r[PW-2:0], qbit};
          rem_r <= qbit ? trial[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_MUL;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        op_r   <= ctl.op;
        cnt_r  <= ctl.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

[rtl/median_ema_moisture_filter.sv]
// Path, accept to out_valid: during window fill the sample goes straight to the percent steps;
// once full: median search over up to WINDOW candidates, 17-step weight multiply, 7-step
// scale multiply, SAMPLE_BITS + 7 step divide; a zero percent skips both of the last two.
// Throughput: one request at a time; the next is taken only back in idle, after the result
// is in the output register, so any result stall holds it up; the arithmetic unit is shared.
// Reset (rst_n low, synchronous): window empty, average zero, calibration 505/205, weight 13107.
module median_ema_moisture_filter import mef_pkg::*; #(
  parameter int WINDOW      = 5,
  parameter int SAMPLE_BITS = 12,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Request channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_raw_sample,
  // Result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_smoothed_level,
  output logic [PCT_BITS-1:0]    out_moisture_percent,
  // Configuration writes
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [WEIGHT_BITS-1:0] cfg_wdata
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int AVG_W  = SAMPLE_BITS + FRAC_BITS;   // unsigned Q(S).F average
  localparam int DW     = AVG_W + 1;                 // signed median - average
  localparam int PW     = DW + WEIGHT_BITS;
  localparam int NW     = SAMPLE_BITS + PCT_MUL_STEPS; // |level - dry| * 100

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MEDIAN = 3'd1;
  localparam logic [2:0] ST_EMA    = 3'd2;
  localparam logic [2:0] ST_PSETUP = 3'd3;
  localparam logic [2:0] ST_PMUL   = 3'd4;
  localparam logic [2:0] ST_PDIV   = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  // Configuration
  logic [SAMPLE_BITS-1:0] dry_r;
  logic [SAMPLE_BITS-1:0] wet_r;
  logic [WEIGHT_BITS-1:0] weight_r;

  // Control state
  logic [2:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              full_r, full_nxt;
  logic [AVG_W-1:0]  avg_r, avg_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Working payload
  logic [SAMPLE_BITS-1:0] level_r, level_nxt;
  logic [SAMPLE_BITS-1:0] den_r, den_nxt;
  logic [PCT_BITS-1:0]    pct_r, pct_nxt;
  logic [SAMPLE_BITS-1:0] out_level_r, out_level_nxt;
  logic [PCT_BITS-1:0]    out_pct_r, out_pct_nxt;

  // Submodule hookup
  logic                   win_we;
  logic                   med_start;
  logic                   med_done;
  logic [SAMPLE_BITS-1:0] med_value;
  mef_ctl_t               unit_ctl;
  logic [DW-1:0]          unit_a;
  logic [WEIGHT_BITS-1:0] unit_b;
  logic                   unit_done;
  logic [PW-1:0]          unit_result;

  // Datapath helpers
  logic                   full_now;
  logic [WEIGHT_BITS-1:0] weight_sat;
  logic [DW-1:0]          ema_diff;
  logic [AVG_W-1:0]       avg_upd;
  logic                   diff_neg;
  logic                   den_neg;
  logic [SAMPLE_BITS-1:0] abs_diff;
  logic [SAMPLE_BITS-1:0] abs_den;
  logic [NW-1:0]          quot;

  mef_median #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_median (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (win_we),
    .wr_slot (slot_r),
    .wr_data (in_raw_sample),
    .start   (med_start),
    .done    (med_done),
    .median  (med_value)
  );

  mef_unit #(
    .OPND_W      (DW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_unit (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (unit_ctl),
    .opnd_a  (unit_a),
    .opnd_b  (unit_b),
    .divisor (den_r),
    .done    (unit_done),
    .result  (unit_result)
  );

  always_comb begin
    // Weights above one saturate to exactly one.
    weight_sat = (weight_r > ALPHA_ONE) ? ALPHA_ONE : weight_r;
    // avg' = avg + floor(w * (median - avg) / 2^16), equal to the weighted blend.
    ema_diff = {1'b0, med_value, {FRAC_BITS{1'b0}}} - {1'b0, avg_r};
    avg_upd  = avg_r + unit_result[ALPHA_BITS +: AVG_W];
    // Calibration signs and magnitudes; the quotient is positive only when
    // level - dry and wet - dry share a sign.
    diff_neg = level_r < dry_r;
    den_neg  = wet_r < dry_r;
    abs_diff = diff_neg ? (dry_r - level_r) : (level_r - dry_r);
    abs_den  = den_neg ? (dry_r - wet_r) : (wet_r - dry_r);
    quot     = unit_result[NW-1:0];
    full_now = full_r | (slot_r == SLOT_W'(WINDOW - 1));
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    full_nxt      = full_r;
    avg_nxt       = avg_r;
    level_nxt     = level_r;
    den_nxt       = den_r;
    pct_nxt       = pct_r;
    out_level_nxt = out_level_r;
    out_pct_nxt   = out_pct_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    win_we        = 1'b0;
    med_start     = 1'b0;
    unit_ctl      = '0;
    unit_a        = '0;
    unit_b        = '0;
    in_ready      = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // Store the sample and advance the circular write slot.
          win_we   = 1'b1;
          slot_nxt = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
          full_nxt = full_now;
          if (full_now) begin
            med_start = 1'b1;
            state_nxt = ST_MEDIAN;
          end else begin
            // Fill phase: pass the sample through and seed the average.
            avg_nxt   = {in_raw_sample, {FRAC_BITS{1'b0}}};
            level_nxt = in_raw_sample;
            state_nxt = ST_PSETUP;
          end
        end
      end
      ST_MEDIAN: begin
        if (med_done) begin
          unit_ctl.start = 1'b1;
          unit_ctl.op    = OP_MUL;
          unit_ctl.steps = STEP_W'(WEIGHT_BITS);
          unit_a         = ema_diff;
          unit_b         = weight_sat;
          state_nxt      = ST_EMA;
        end
      end
      ST_EMA: begin
        if (unit_done) begin
          avg_nxt   = avg_upd;
          level_nxt = avg_upd[AVG_W-1:FRAC_BITS];
          state_nxt = ST_PSETUP;
        end
      end
      ST_PSETUP: begin
        // Equal points, a level on the dry point, or a negative ratio give 0.
        if ((dry_r == wet_r) || (level_r == dry_r) || (diff_neg != den_neg)) begin
          pct_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          unit_ctl.start = 1'b1;
          unit_ctl.op    = OP_MUL;
          unit_ctl.steps = STEP_W'(PCT_MUL_STEPS);
          unit_a         = DW'(abs_diff);
          unit_b         = PCT_SCALE_ALIGNED;
          den_nxt        = abs_den;
          state_nxt      = ST_PMUL;
        end
      end
      ST_PMUL: begin
        if (unit_done) begin
          unit_ctl.start = 1'b1;
          unit_ctl.op    = OP_DIV;
          unit_ctl.steps = STEP_W'(NW);
          unit_a         = DW'(unit_result[NW-1:0]);
          state_nxt      = ST_PDIV;
        end
      end
      ST_PDIV: begin
        if (unit_done) begin
          // Clamp to 100 percent.
          pct_nxt   = (quot > NW'(PCT_MAX)) ? PCT_MAX : quot[PCT_BITS-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // Hold until the output register is free, then hand the result over.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = level_r;
          out_pct_nxt   = pct_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      full_r      <= 1'b0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
      dry_r       <= SAMPLE_BITS'(DRY_RESET);
      wet_r       <= SAMPLE_BITS'(WET_RESET);
      weight_r    <= WEIGHT_RESET;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      full_r      <= full_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_DRY_POINT: dry_r    <= cfg_wdata[SAMPLE_BITS-1:0];
          REG_WET_POINT: wet_r    <= cfg_wdata[SAMPLE_BITS-1:0];
          REG_WEIGHT:    weight_r <= cfg_wdata;
          default: begin
            // Drop writes beyond the register list.
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    level_r     <= level_nxt;
    den_r       <= den_nxt;
    pct_r       <= pct_nxt;
    out_level_r <= out_level_nxt;
    out_pct_r   <= out_pct_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_smoothed_level   = out_level_r;
  assign out_moisture_percent = out_pct_r;

endmodule

[verif/tb.sv]
// Self-checking testbench for the median + moving-average soil-moisture filter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mef_pkg::*;

  localparam int WIN      = 5;
  localparam int SAMPLE_W = 12;
  localparam int FRAC_W   = 16;

  // Longest request-to-result path, padded a little.
  localparam int SETTLE_CYCLES  = WIN + SAMPLE_W + 45;
  // Cycles with no accepted request and no accepted result before giving up.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_PRINTS     = 40;
  localparam int HOLD_OFF_LEN   = 400;

  // Register indexes past the end of the map; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX   = '1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic [PCT_BITS-1:0] percent;
  } reading_t;

  // ---------------------------------------------------------------------------
  // DUT connections; every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                   clk                  = 1'b0;
  logic                   rst_n                = 1'b0;
  logic                   in_valid             = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_W-1:0]    in_raw_sample        = '0;
  logic                   out_valid;
  logic                   out_ready            = 1'b0;
  logic [SAMPLE_W-1:0]    out_smoothed_level;
  logic [PCT_BITS-1:0]    out_moisture_percent;
  logic                   cfg_wr_en            = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index            = '0;
  logic [WEIGHT_BITS-1:0] cfg_wdata            = '0;

  median_ema_moisture_filter #(
    .WINDOW      (WIN),
    .SAMPLE_BITS (SAMPLE_W),
    .FRAC_BITS   (FRAC_W)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_raw_sample        (in_raw_sample),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_smoothed_level   (out_smoothed_level),
    .out_moisture_percent (out_moisture_percent),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Filter predictor: own copy of window, average and calibration.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0]    win_samples [WIN];
  int                     win_slot    = 0;
  logic                   win_full    = 1'b0;
  logic [63:0]            ema_acc     = '0;   // unsigned Q12.16
  logic [SAMPLE_W-1:0]    cal_dry     = SAMPLE_W'(DRY_RESET);
  logic [SAMPLE_W-1:0]    cal_wet     = SAMPLE_W'(WET_RESET);
  logic [WEIGHT_BITS-1:0] ema_weight  = WEIGHT_RESET;

  reading_t expected_readings [$];

  int mismatch_count = 0;
  int send_idle_pct  = 0;   // chance per cycle that the sender holds back
  int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
  int hold_off_left  = 0;   // long receiver hold-off, counted down below
  int walk_level     = 350;
  int stalled_cycles = 0;

  // Insertion sort of a window copy; the middle entry is the median.
  function automatic logic [SAMPLE_W-1:0] window_median();
    logic [SAMPLE_W-1:0] v [WIN];
    logic [SAMPLE_W-1:0] key;
    int j;
    for (int i = 0; i < WIN; i++) v[i] = win_samples[i];
    for (int i = 1; i < WIN; i++) begin
      key = v[i];
      j   = i - 1;
      while (j >= 0 && v[j] > key) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = key;
    end
    return v[WIN / 2];
  endfunction

  // Linear map dry -> 0 %, wet -> 100 %, truncate toward zero, clamp.
  function automatic logic [PCT_BITS-1:0] level_to_percent(logic [SAMPLE_W-1:0] level);
    longint x, d, w, p;
    x = level;
    d = cal_dry;
    w = cal_wet;
    if (d == w) return '0;
    p = ((x - d) * 100) / (w - d);
    if (p < 0) p = 0;
    if (p > 100) p = 100;
    return PCT_BITS'(p);
  endfunction

  // Advance the predictor by one sample and return the reading it must produce.
  function automatic reading_t filter_sample(logic [SAMPLE_W-1:0] raw);
    logic [63:0]         a;
    logic [63:0]         med_fx;
    logic [SAMPLE_W-1:0] level;
    reading_t            r;
    win_samples[win_slot] = raw;
    win_slot++;
    if (win_slot >= WIN) begin
      win_slot = 0;
      win_full = 1'b1;
    end
    if (!win_full) begin
      // fill phase: pass through and seed the average
      ema_acc = 64'(raw) << FRAC_W;
      level   = raw;
    end else begin
      a       = (ema_weight > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(ema_weight);
      med_fx  = 64'(window_median()) << FRAC_W;
      ema_acc = (a * med_fx + (64'(ALPHA_ONE) - a) * ema_acc) >> ALPHA_BITS;
      level   = SAMPLE_W'(ema_acc >> FRAC_W);
    end
    r.level   = level;
    r.percent = level_to_percent(level);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and request capture, both sampled at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    reading_t want;
    if (rst_n) begin
      // check first: a result can never belong to a request taken on the same edge
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("result with nothing pending, level", out_smoothed_level, 0);
        end else begin
          want = expected_readings.pop_front();
          if (out_smoothed_level !== want.level)
            report_mismatch("smoothed_level", out_smoothed_level, want.level);
          if (out_moisture_percent !== want.percent)
            report_mismatch("moisture_percent", out_moisture_percent, want.percent);
        end
      end
      if (in_valid && in_ready)
        expected_readings.push_back(filter_sample(in_raw_sample));
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_ready <= 1'b0;
      hold_off_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stalled_cycles = 0;
    else
      stalled_cycles++;
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one request after a random gap; return on the edge that accepts it.
  // Valid stays high afterwards so back-to-back requests need no extra edge.
  task automatic send_sample(logic [SAMPLE_W-1:0] raw);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_raw_sample <= raw;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every pending result, then let the pipeline settle.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One-cycle register write; only called while the block is idle.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [WEIGHT_BITS-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_DRY_POINT: cal_dry    = value[SAMPLE_W-1:0];
      REG_WET_POINT: cal_wet    = value[SAMPLE_W-1:0];
      REG_WEIGHT:    ema_weight = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_calibration(int dry, int wet, int weight);
    write_register(REG_DRY_POINT, WEIGHT_BITS'(dry));
    write_register(REG_WET_POINT, WEIGHT_BITS'(wet));
    write_register(REG_WEIGHT, WEIGHT_BITS'(weight));
  endtask

  // Sensor-like samples: a slow random walk, some spikes, some full-range noise.
  function automatic logic [SAMPLE_W-1:0] next_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return SAMPLE_W'($urandom_range(4095));
    if (pick < 16) return $urandom_range(1) ? {SAMPLE_W{1'b1}} : '0;
    if (pick < 19) walk_level = $urandom_range(4095);
    walk_level = walk_level + int'($urandom_range(64)) - 32;
    if (walk_level < 0) walk_level = 0;
    if (walk_level > 4095) walk_level = 4095;
    return SAMPLE_W'(walk_level);
  endfunction

  // Calibration settings visited by the random traffic, extremes included.
  task automatic pick_calibration(int k);
    case (k % 8)
      0: set_calibration(DRY_RESET, WET_RESET, WEIGHT_RESET);
      1: set_calibration(0, 4095, 65536);
      2: set_calibration(4095, 0, 0);
      3: set_calibration(1000, 1000, 131071);
      4: set_calibration(205, 505, 1);
      5: set_calibration(4095, 4095, 65535);
      6: set_calibration($urandom_range(150, 700), $urandom_range(150, 700),
                         $urandom_range(1000, 40000));
      default: set_calibration($urandom_range(4095), $urandom_range(4095),
                               $urandom_range(131071));
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fill phase, weight extremes, equal points, clamping, unused indexes and dropped upper bits.
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // fill the window under reset calibration; the fifth sample takes the median path
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd505);
    send_sample(12'd205);
    send_sample(12'd355);
    // weight of one: the average jumps to the median
    wait_for_results();
    write_register(REG_WEIGHT, ALPHA_ONE);
    repeat (3) send_sample(12'd4095);
    repeat (2) send_sample(12'd0);
    // weight of zero: the average holds
    wait_for_results();
    write_register(REG_WEIGHT, '0);
    send_sample(12'd1234);
    send_sample(12'd4095);
    // weight above one saturates
    wait_for_results();
    write_register(REG_WEIGHT, '1);
    send_sample(12'd100);
    send_sample(12'd3000);
    // equal calibration points give zero percent
    wait_for_results();
    set_calibration(2000, 2000, WEIGHT_RESET);
    send_sample(12'd2000);
    send_sample(12'd1999);
    // writes past the register map change nothing
    wait_for_results();
    write_register(REG_FIRST_UNUSED, '0);
    write_register(REG_LAST_INDEX, '1);
    send_sample(12'd7);
    // upper data bits above the point width are dropped
    wait_for_results();
    write_register(REG_DRY_POINT, 17'h1F12C);
    write_register(REG_WET_POINT, 17'd4095);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd2048);
    wait_for_results();
  endtask

  // Random samples over every idling mix and a spread of calibrations.
  task automatic test_random_traffic();
    int send_mix [4] = '{0, 83, 0, 23};
    int recv_mix [4] = '{0, 0, 83, 23};
    for (int phase = 0; phase < 4; phase++) begin
      for (int sub = 0; sub < 2; sub++) begin
        pick_calibration(phase * 2 + sub);
        send_idle_pct  = send_mix[phase];
        recv_stall_pct = recv_mix[phase];
        repeat (200) send_sample(next_sample());
        wait_for_results();
      end
    end
  endtask

  // Hold the receiver off while requests keep coming, so the block backs up.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pick_calibration(6);
    @(posedge clk);
    hold_off_left = HOLD_OFF_LEN;
    repeat (40) send_sample(next_sample());
    wait_for_results();
  endtask

  // Pause the sender until everything is out, then resume with the same state.
  task automatic test_drain_pause();
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    pick_calibration(0);
    repeat (30) send_sample(next_sample());
    wait_for_results();
    repeat (30) send_sample(next_sample());
    wait_for_results();
  endtask

  initial begin
    for (int i = 0; i < WIN; i++) win_samples[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_traffic();
    test_backpressure();
    test_drain_pause();

    wait_for_results();
    if (expected_readings.size() != 0)
      report_mismatch("results never delivered", 0, expected_readings.size());
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
